>>> rtl/psng_pkg.sv
// psng_pkg: shared widths, codes and the stencil step table for the
// periodic stencil neighbor generator; no dependencies
`timescale 1ns / 1ps

package psng_pkg;

   localparam int SITE_W      = 24;
   localparam int SLOT_W      = 5;
   localparam int SIZE_REG_W  = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int SIZE_RESET  = 16;
   localparam int FACE_COUNT  = 6;
   localparam int FULL_COUNT  = 18;
   localparam int DIV_STEPS   = 4;
   localparam int DIV_ITERS   = SITE_W / DIV_STEPS;
   localparam int DIV_CNT_W   = $clog2(DIV_ITERS);
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STENCIL_MODE = 2'd0,
      CSR_SIZE_X       = 2'd1,
      CSR_SIZE_Y       = 2'd2,
      CSR_SIZE_Z       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      FS_IDLE,
      FS_DIV_X,
      FS_DIV_Y,
      FS_DONE
   } front_state_type;

   typedef enum logic [1:0] {
      STEP_HOLD,
      STEP_DEC,
      STEP_INC
   } step_type;

   typedef struct packed {
      step_type dx;
      step_type dy;
      step_type dz;
   } stencil_step_type;

   // fixed stencil order: faces first, then edge diagonals
   function automatic stencil_step_type slot_step(input logic [SLOT_W-1:0] slot);
      stencil_step_type s;
      s = '{STEP_HOLD, STEP_HOLD, STEP_HOLD};
      case (slot)
         5'd0:    s = '{STEP_DEC,  STEP_HOLD, STEP_HOLD};
         5'd1:    s = '{STEP_INC,  STEP_HOLD, STEP_HOLD};
         5'd2:    s = '{STEP_HOLD, STEP_DEC,  STEP_HOLD};
         5'd3:    s = '{STEP_HOLD, STEP_INC,  STEP_HOLD};
         5'd4:    s = '{STEP_HOLD, STEP_HOLD, STEP_DEC};
         5'd5:    s = '{STEP_HOLD, STEP_HOLD, STEP_INC};
         5'd6:    s = '{STEP_DEC,  STEP_DEC,  STEP_HOLD};
         5'd7:    s = '{STEP_DEC,  STEP_INC,  STEP_HOLD};
         5'd8:    s = '{STEP_DEC,  STEP_HOLD, STEP_DEC};
         5'd9:    s = '{STEP_DEC,  STEP_HOLD, STEP_INC};
         5'd10:   s = '{STEP_INC,  STEP_DEC,  STEP_HOLD};
         5'd11:   s = '{STEP_INC,  STEP_INC,  STEP_HOLD};
         5'd12:   s = '{STEP_INC,  STEP_HOLD, STEP_DEC};
         5'd13:   s = '{STEP_INC,  STEP_HOLD, STEP_INC};
         5'd14:   s = '{STEP_HOLD, STEP_DEC,  STEP_DEC};
         5'd15:   s = '{STEP_HOLD, STEP_DEC,  STEP_INC};
         5'd16:   s = '{STEP_HOLD, STEP_INC,  STEP_DEC};
         5'd17:   s = '{STEP_HOLD, STEP_INC,  STEP_INC};
         default: s = '{STEP_HOLD, STEP_HOLD, STEP_HOLD};
      endcase
      return s;
   endfunction

endpackage

>>> rtl/psng_req_if.sv
// psng_req_if: target site channel, valid/ready with the site index
// depends on psng_pkg
`timescale 1ns / 1ps

interface psng_req_if;
   import psng_pkg::*;

   logic              valid;
   logic              ready;
   logic [SITE_W-1:0] site_index;

   modport source (output valid, output site_index, input ready);
   modport sink   (input valid, input site_index, output ready);
endinterface

>>> rtl/psng_rsp_if.sv
// psng_rsp_if: neighbor result channel, valid/ready with one neighbor per beat
// depends on psng_pkg
`timescale 1ns / 1ps

interface psng_rsp_if;
   import psng_pkg::*;

   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] neighbor_slot;
   logic [SITE_W-1:0] neighbor_site;
   logic              last_neighbor;
   logic              out_of_range;

   modport source (output valid, output neighbor_slot, output neighbor_site,
                   output last_neighbor, output out_of_range, input ready);
   modport sink   (input valid, input neighbor_slot, input neighbor_site,
                   input last_neighbor, input out_of_range, output ready);
endinterface

>>> rtl/psng_csr_if.sv
// psng_csr_if: register write channel, valid/ready with index and data
// depends on psng_pkg
`timescale 1ns / 1ps

interface psng_csr_if;
   import psng_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/psng_queue.sv
// psng_queue: short fifo between the decode front and the emit back
// depends on psng_pkg for the depth
`timescale 1ns / 1ps

module psng_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import psng_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/psng_front.sv
// psng_front: takes target sites and splits them into x, y, z with a
// radix-16 restoring divider; depends on psng_pkg and psng_req_if
`timescale 1ns / 1ps

module psng_front #(
   parameter  int SIDE_MAX = 256,
   localparam int SW       = $clog2(SIDE_MAX + 1),
   localparam int CW       = $clog2(SIDE_MAX)
) (
   input  logic          clock,
   input  logic          reset,
   psng_req_if.sink      req_bus,
   input  logic [SW-1:0] sx,
   input  logic [SW-1:0] sy,
   input  logic [SW-1:0] sz,
   output logic          push_valid,
   input  logic          push_ready,
   output logic          push_oor,
   output logic [CW-1:0] push_x,
   output logic [CW-1:0] push_y,
   output logic [CW-1:0] push_z
);
   import psng_pkg::*;

   front_state_type        state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SITE_W-1:0]      dvd_ff;
   logic [SW-1:0]          rem_ff;
   logic [CW-1:0]          x_ff, y_ff, z_ff;
   logic                   oor_ff;
   logic [SW-1:0]          divisor;
   logic [SITE_W-1:0]      q_step;
   logic [SW-1:0]          r_step;
   logic [SW:0]            trial;
   logic                   accept;
   logic                   any_zero;
   logic                   div_last;
   logic                   dividing;
   logic                   z_over;

   assign divisor  = (state_ff == FS_DIV_Y) ? sy : sx;
   assign any_zero = (sx == '0) || (sy == '0) || (sz == '0);
   assign div_last = cnt_ff == DIV_CNT_W'(DIV_ITERS - 1);
   assign dividing = (state_ff == FS_DIV_X) || (state_ff == FS_DIV_Y);
   assign accept   = req_bus.valid && req_bus.ready;
   assign z_over   = q_step >= SITE_W'(sz);

   // four quotient bits per cycle
   always_comb begin
      q_step = dvd_ff;
      r_step = rem_ff;
      trial  = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial  = {r_step, q_step[SITE_W-1]};
         q_step = {q_step[SITE_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial     = trial - {1'b0, divisor};
            q_step[0] = 1'b1;
         end
         r_step = trial[SW-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_bus.ready = 1'b0;
      push_valid    = 1'b0;
      case (state_ff)
         FS_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               state_in = any_zero ? FS_DONE : FS_DIV_X;
            end
         end
         FS_DIV_X: begin
            if (div_last) begin
               state_in = FS_DIV_Y;
            end
         end
         FS_DIV_Y: begin
            if (div_last) begin
               state_in = FS_DONE;
            end
         end
         FS_DONE: begin
            push_valid = 1'b1;
            if (push_ready) begin
               req_bus.ready = 1'b1;
               if (req_bus.valid) begin
                  state_in = any_zero ? FS_DONE : FS_DIV_X;
               end else begin
                  state_in = FS_IDLE;
               end
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = '0;
      end else if (dividing) begin
         cnt_in = div_last ? '0 : cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dvd_ff <= req_bus.site_index;
         rem_ff <= '0;
         oor_ff <= any_zero;
      end else if (dividing) begin
         dvd_ff <= q_step;
         rem_ff <= div_last ? '0 : r_step;
         if (div_last && state_ff == FS_DIV_X) begin
            x_ff <= CW'(r_step);
         end
         if (div_last && state_ff == FS_DIV_Y) begin
            y_ff   <= CW'(r_step);
            z_ff   <= CW'(q_step);
            oor_ff <= z_over;
         end
      end
   end

   assign push_oor = oor_ff;
   assign push_x   = x_ff;
   assign push_y   = y_ff;
   assign push_z   = z_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> cnt_ff == '0 && (state_ff == FS_DIV_X || state_ff == FS_DONE))
      else $error("front did not restart on a new target");

   a_x_then_y: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FS_DIV_X && div_last) |=> state_ff == FS_DIV_Y)
      else $error("x division did not hand over to y division");

   a_push_holds: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !push_ready) |=> state_ff == FS_DONE && $stable(x_ff) && $stable(oor_ff))
      else $error("decoded site changed while waiting for queue space");
`endif

endmodule

>>> rtl/psng_back.sv
// psng_back: walks the stencil slots of each decoded site and forms the
// wrapped neighbor index in a three-stage pipe; depends on psng_pkg, psng_rsp_if
`timescale 1ns / 1ps

module psng_back #(
   parameter  int SIDE_MAX   = 256,
   parameter  int INDEX_BITS = 24,
   localparam int SW         = $clog2(SIDE_MAX + 1),
   localparam int CW         = $clog2(SIDE_MAX)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          mode,
   input  logic [SW-1:0] sx,
   input  logic [SW-1:0] sy,
   input  logic [SW-1:0] sz,
   input  logic          ent_valid,
   output logic          ent_pop,
   input  logic          ent_oor,
   input  logic [CW-1:0] ent_x,
   input  logic [CW-1:0] ent_y,
   input  logic [CW-1:0] ent_z,
   psng_rsp_if.source    rsp_bus
);
   import psng_pkg::*;

   localparam int TW = SW + CW + 1;
   localparam int LW = SW + TW + 1;
   localparam logic [SITE_W-1:0] SITE_MASK = SITE_W'((64'd1 << INDEX_BITS) - 64'd1);

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] count_last;
   logic              adv;
   logic              issue;
   logic              issue_last;
   stencil_step_type  step;
   logic [CW-1:0]     nx_c, ny_c, nz_c;

   logic              v1_ff, v2_ff, out_valid_ff;
   logic [SLOT_W-1:0] slot1_ff, slot2_ff, out_slot_ff;
   logic              last1_ff, last2_ff, out_last_ff;
   logic              oor1_ff, oor2_ff, out_oor_ff;
   logic [CW-1:0]     nx1_ff, ny1_ff, nz1_ff, nx2_ff;
   logic [TW-1:0]     t2_in, t2_ff;
   logic [LW-1:0]     lin;
   logic [SITE_W-1:0] out_site_ff;

   function automatic logic [CW-1:0] wrap_coord(input logic [CW-1:0] c, input step_type d,
                                                input logic [SW-1:0] s);
      logic [SW-1:0] up;
      logic [CW-1:0] r;
      up = SW'(c) + SW'(1);
      case (d)
         STEP_DEC: r = (c == '0) ? CW'(s - SW'(1)) : c - CW'(1);
         STEP_INC: r = (up >= s) ? '0 : CW'(up);
         default:  r = c;
      endcase
      return r;
   endfunction

   assign adv        = !out_valid_ff || rsp_bus.ready;
   assign count_last = mode ? SLOT_W'(FULL_COUNT - 1) : SLOT_W'(FACE_COUNT - 1);
   assign issue      = ent_valid && adv;
   assign issue_last = ent_oor || (slot_ff >= count_last);
   assign ent_pop    = issue && issue_last;

   assign step = slot_step(slot_ff);
   assign nx_c = wrap_coord(ent_x, step.dx, sx);
   assign ny_c = wrap_coord(ent_y, step.dy, sy);
   assign nz_c = wrap_coord(ent_z, step.dz, sz);

   always_comb begin
      slot_in = slot_ff;
      if (issue) begin
         slot_in = issue_last ? '0 : slot_ff + SLOT_W'(1);
      end
   end

   assign t2_in = TW'(ny1_ff) + TW'(sy) * TW'(nz1_ff);
   assign lin   = LW'(nx2_ff) + LW'(sx) * LW'(t2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         if (adv) begin
            v1_ff        <= issue;
            v2_ff        <= v1_ff;
            out_valid_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         slot1_ff    <= slot_ff;
         last1_ff    <= issue_last;
         oor1_ff     <= ent_oor;
         nx1_ff      <= nx_c;
         ny1_ff      <= ny_c;
         nz1_ff      <= nz_c;
         slot2_ff    <= slot1_ff;
         last2_ff    <= last1_ff;
         oor2_ff     <= oor1_ff;
         nx2_ff      <= nx1_ff;
         t2_ff       <= t2_in;
         out_slot_ff <= oor2_ff ? '0 : slot2_ff;
         out_site_ff <= oor2_ff ? '0 : (SITE_W'(lin) & SITE_MASK);
         out_last_ff <= last2_ff;
         out_oor_ff  <= oor2_ff;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.neighbor_slot = out_slot_ff;
   assign rsp_bus.neighbor_site = out_site_ff;
   assign rsp_bus.last_neighbor = out_last_ff;
   assign rsp_bus.out_of_range  = out_oor_ff;

`ifndef NO_ASSERTIONS
   a_pop_rewinds: assert property (@(posedge clock) disable iff (reset)
      ent_pop |=> slot_ff == '0)
      else $error("slot counter not rewound after last neighbor");

   a_slot_steps: assert property (@(posedge clock) disable iff (reset)
      (issue && !issue_last) |=> slot_ff == $past(slot_ff) + SLOT_W'(1))
      else $error("slot counter skipped a neighbor");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff < SLOT_W'(FULL_COUNT))
      else $error("slot counter beyond the stencil");

   a_oor_alone: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_oor_ff) |-> out_last_ff && out_slot_ff == '0)
      else $error("out of range beat not a sole result");
`endif

endmodule

>>> rtl/periodic_stencil_neighbor_generator_core.sv
// periodic_stencil_neighbor_generator_core: decodes a site index and streams
// its 6 (mode 0) or 18 (mode 1) periodic neighbors, or one out-of-range beat.
// A target's beats follow one per cycle while the receiver is ready. The front
// decodes the next target, by x and y divisions at 4 quotient bits per cycle,
// while the back still emits the last one's beats. Reset: mode 0, sizes 16, pipe empty.
`timescale 1ns / 1ps

module periodic_stencil_neighbor_generator_core #(
   parameter int SIDE_MAX   = 256,
   parameter int INDEX_BITS = 24
) (
   input logic        clock,
   input logic        reset,
   psng_req_if.sink   req_bus,
   psng_rsp_if.source rsp_bus,
   psng_csr_if.sink   csr_bus
);
   import psng_pkg::*;

   localparam int SW = $clog2(SIDE_MAX + 1);
   localparam int CW = $clog2(SIDE_MAX);
   localparam int QW = 1 + 3 * CW;

   logic                  mode_ff;
   logic [SIZE_REG_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [SW-1:0]         sx, sy, sz;
   logic                  push_valid, push_ready, push_oor;
   logic [CW-1:0]         push_x, push_y, push_z;
   logic                  pop_valid, pop_ready;
   logic [QW-1:0]         pop_data;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         size_x_ff <= SIZE_REG_W'(SIZE_RESET);
         size_y_ff <= SIZE_REG_W'(SIZE_RESET);
         size_z_ff <= SIZE_REG_W'(SIZE_RESET);
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_index_type'(csr_bus.index))
            CSR_STENCIL_MODE: mode_ff   <= csr_bus.data[0];
            CSR_SIZE_X:       size_x_ff <= SIZE_REG_W'(csr_bus.data);
            CSR_SIZE_Y:       size_y_ff <= SIZE_REG_W'(csr_bus.data);
            CSR_SIZE_Z:       size_z_ff <= SIZE_REG_W'(csr_bus.data);
            default:          ;
         endcase
      end
   end

   // sides above the lattice limit are taken at the limit
   assign sx = (int'(size_x_ff) > SIDE_MAX) ? SW'(SIDE_MAX) : SW'(size_x_ff);
   assign sy = (int'(size_y_ff) > SIDE_MAX) ? SW'(SIDE_MAX) : SW'(size_y_ff);
   assign sz = (int'(size_z_ff) > SIDE_MAX) ? SW'(SIDE_MAX) : SW'(size_z_ff);

   psng_front #(
      .SIDE_MAX (SIDE_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .sx         (sx),
      .sy         (sy),
      .sz         (sz),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_oor   (push_oor),
      .push_x     (push_x),
      .push_y     (push_y),
      .push_z     (push_z)
   );

   psng_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_oor, push_z, push_y, push_x}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   psng_back #(
      .SIDE_MAX   (SIDE_MAX),
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .sx        (sx),
      .sy        (sy),
      .sz        (sz),
      .ent_valid (pop_valid),
      .ent_pop   (pop_ready),
      .ent_oor   (pop_data[QW-1]),
      .ent_x     (pop_data[CW-1:0]),
      .ent_y     (pop_data[2*CW-1:CW]),
      .ent_z     (pop_data[3*CW-1:2*CW]),
      .rsp_bus   (rsp_bus)
   );

endmodule
